FILE: sv/lprip_pkg.sv
`default_nettype none

package lprip_pkg;

  // Angle constants, units of 2^-24 rad
  localparam logic signed [27:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [27:0] ANG_HALF_PI = 28'sd26353589;

  // Squared range at or below which a point is too close (0.1 m)
  localparam logic [47:0] MIN_RANGE_SQ = 48'd167772;

  localparam int CORDIC_STEPS = 24;

  // Image bounds
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 2048;

  // Register reset values
  localparam logic [6:0]  RST_ROW_COUNT     = 7'd16;
  localparam logic [11:0] RST_COLUMN_COUNT  = 12'd1800;
  localparam logic [25:0] RST_BOTTOM_OFFSET = 26'd4421581;
  localparam logic [25:0] RST_ROW_STEP      = 26'd585635;
  localparam logic [25:0] RST_COLUMN_STEP   = 26'd58564;

  // Register word indexes
  typedef enum logic [2:0] {
    REG_ROW_COUNT     = 3'd0,
    REG_COLUMN_COUNT  = 3'd1,
    REG_BOTTOM_OFFSET = 3'd2,
    REG_ROW_STEP      = 3'd3,
    REG_COLUMN_STEP   = 3'd4
  } reg_idx_t;

  // Arctangent of 2^-i, units of 2^-24 rad
  function automatic logic signed [27:0] atan_val(input logic [4:0] idx);
    logic signed [27:0] v;
    case (idx)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lidar_point_range_image_projector_core.sv
// A point passes through 89 register stages, stg[0] to stg[LAST], before its result is presented.
// Throughput: one point per cycle; every stage advances together whenever the output
// register is empty or being taken, so a full pipeline streams at one transaction a cycle.
// Depth is set by the two squares, the 32-step horizontal root, the 24-step elevation
// CORDIC and the 28-step divider; the azimuth CORDIC runs beside the root.
// Reset (synchronous, active high) clears all valid bits and loads the register defaults.
`default_nettype none

module lidar_point_range_image_projector_core (
  input  wire logic               clk,
  input  wire logic               rst,
  // point input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic signed [23:0] pos_z,
  // result output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    keep,
  output logic [5:0]              row,
  output logic [10:0]             column,
  output logic [23:0]             distance,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Stage schedule
  localparam int AZ_FIRST = 1;
  localparam int SQ_FIRST = 2;
  localparam int HSQ_STEPS = 32;
  localparam int SSQ_STEPS = 24;
  localparam int EL_FIRST = SQ_FIRST + HSQ_STEPS;
  localparam int PRE_DIV  = EL_FIRST + lprip_pkg::CORDIC_STEPS;
  localparam int DIV_FIRST = PRE_DIV + 1;
  localparam int ROW_QW   = 27;
  localparam int COL_QW   = 28;
  localparam int COL_STG  = DIV_FIRST + COL_QW;
  localparam int LAST     = COL_STG + 1;

  typedef struct packed {
    logic signed [47:0] s;
    logic signed [47:0] c;
    logic signed [27:0] ang;
  } cord_t;

  typedef struct packed {
    logic signed [23:0] pz;
    logic [47:0]        xx;
    logic [47:0]        yy;
    logic [47:0]        zz;
    logic [63:0]        h_rem;
    logic [63:0]        h_res;
    logic [47:0]        s_rem;
    logic [47:0]        s_res;
    logic               short_range;
    cord_t              az;
    cord_t              el;
    logic               r_neg;
    logic [26:0]        r_num;
    logic [27:0]        r_rem;
    logic [26:0]        r_q;
    logic               c_neg;
    logic [27:0]        c_num;
    logic [26:0]        c_den;
    logic [28:0]        c_rem;
    logic [27:0]        c_q;
    logic [31:0]        col;
    logic               keep_o;
    logic [5:0]         row_o;
    logic [10:0]        col_o;
  } pipe_t;

  // Configuration registers
  logic [6:0]  row_count;
  logic [11:0] column_count;
  logic [25:0] bottom_offset;
  logic [25:0] row_step;
  logic [25:0] column_step;

  pipe_t stg [0:LAST];
  pipe_t nxt [0:LAST];
  logic  vld [0:LAST];
  logic  en;

  // One CORDIC vectoring step
  function automatic cord_t cord_iter(input cord_t v, input int i);
    logic signed [47:0] sv;
    logic signed [47:0] cv;
    logic signed [47:0] dc;
    logic signed [47:0] ds;
    cord_t r;
    sv = v.s;
    cv = v.c;
    dc = sv >>> i;
    ds = cv >>> i;
    r = v;
    if (!sv[47]) begin
      r.c   = cv + dc;
      r.s   = sv - ds;
      r.ang = v.ang + lprip_pkg::atan_val(5'(i));
    end else begin
      r.c   = cv - dc;
      r.s   = sv + ds;
      r.ang = v.ang - lprip_pkg::atan_val(5'(i));
    end
    return r;
  endfunction

  // Register writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= lprip_pkg::RST_ROW_COUNT;
      column_count  <= lprip_pkg::RST_COLUMN_COUNT;
      bottom_offset <= lprip_pkg::RST_BOTTOM_OFFSET;
      row_step      <= lprip_pkg::RST_ROW_STEP;
      column_step   <= lprip_pkg::RST_COLUMN_STEP;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        lprip_pkg::REG_ROW_COUNT:     row_count     <= pwdata[6:0];
        lprip_pkg::REG_COLUMN_COUNT:  column_count  <= pwdata[11:0];
        lprip_pkg::REG_BOTTOM_OFFSET: bottom_offset <= pwdata[25:0];
        lprip_pkg::REG_ROW_STEP:      row_step      <= pwdata[25:0];
        lprip_pkg::REG_COLUMN_STEP:   column_step   <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lprip_pkg::REG_ROW_COUNT:     prdata = {25'b0, row_count};
      lprip_pkg::REG_COLUMN_COUNT:  prdata = {20'b0, column_count};
      lprip_pkg::REG_BOTTOM_OFFSET: prdata = {6'b0, bottom_offset};
      lprip_pkg::REG_ROW_STEP:      prdata = {6'b0, row_step};
      lprip_pkg::REG_COLUMN_STEP:   prdata = {6'b0, column_step};
      default:                      prdata = 32'b0;
    endcase
  end

  // Advance every stage unless the output register holds an untaken transaction
  assign en        = !vld[LAST] || out_ready;
  assign in_ready  = en && !rst;
  assign out_valid = vld[LAST];
  assign keep      = stg[LAST].keep_o;
  assign row       = stg[LAST].row_o;
  assign column    = stg[LAST].col_o;
  assign distance  = stg[LAST].s_res[23:0];

  for (genvar k = 0; k <= LAST; k++) begin : g_stage
    localparam int PK = (k == 0) ? 0 : k - 1;
    localparam int AI = (k >= AZ_FIRST && k < AZ_FIRST + lprip_pkg::CORDIC_STEPS)
                        ? k - AZ_FIRST : 0;
    localparam int HI = (k >= SQ_FIRST && k < SQ_FIRST + HSQ_STEPS) ? k - SQ_FIRST : 0;
    localparam int SI = (k >= SQ_FIRST && k < SQ_FIRST + SSQ_STEPS) ? k - SQ_FIRST : 0;
    localparam int EI = (k >= EL_FIRST && k < EL_FIRST + lprip_pkg::CORDIC_STEPS)
                        ? k - EL_FIRST : 0;
    localparam int RB = (k >= DIV_FIRST && k < DIV_FIRST + ROW_QW)
                        ? ROW_QW - 1 - (k - DIV_FIRST) : 0;
    localparam int CB = (k >= DIV_FIRST && k < DIV_FIRST + COL_QW)
                        ? COL_QW - 1 - (k - DIV_FIRST) : 0;

    always_comb begin
      pipe_t              p;
      logic signed [47:0] sq;
      logic [47:0]        hsq;
      logic [47:0]        ssq;
      logic [63:0]        hbit;
      logic [47:0]        sbit;
      cord_t              ce;
      logic [28:0]        n;
      logic [28:0]        nm;
      logic [28:0]        a;
      logic [28:0]        am;
      logic [27:0]        rr;
      logic [28:0]        cr;
      logic [31:0]        q2;
      logic [31:0]        v;
      logic [31:0]        nv;
      logic [31:0]        col2;
      logic               row_ok;
      logic               col_ok;

      if (k == 0) begin
        p = '0;
      end else begin
        p = stg[PK];
      end
      hsq    = '0;
      ssq    = '0;
      hbit   = '0;
      sbit   = '0;
      ce     = '0;
      n      = '0;
      nm     = '0;
      a      = '0;
      am     = '0;
      rr     = '0;
      cr     = '0;
      q2     = '0;
      v      = '0;
      nv     = '0;
      col2   = '0;
      row_ok = 1'b0;
      col_ok = 1'b0;

      // Squares and azimuth pre-rotation
      if (k == 0) begin
        p.pz = pos_z;
        sq = {{24{pos_x[23]}}, pos_x};
        p.xx = 48'(sq * sq);
        sq = {{24{pos_y[23]}}, pos_y};
        p.yy = 48'(sq * sq);
        sq = {{24{pos_z[23]}}, pos_z};
        p.zz = 48'(sq * sq);
        p.az.s   = {{4{pos_x[23]}}, pos_x, 20'b0};
        p.az.c   = {{4{pos_y[23]}}, pos_y, 20'b0};
        p.az.ang = '0;
        if (pos_y[23]) begin
          p.az.ang = pos_x[23] ? -lprip_pkg::ANG_PI : lprip_pkg::ANG_PI;
          p.az.s   = -p.az.s;
          p.az.c   = -p.az.c;
        end
      end else begin
        sq = '0;
      end

      // Sums of squares, start both roots
      if (k == 1) begin
        hsq = p.xx + p.yy;
        ssq = hsq + p.zz;
        p.h_rem = {hsq, 16'b0};
        p.h_res = '0;
        p.s_rem = ssq;
        p.s_res = '0;
        p.short_range = (ssq <= lprip_pkg::MIN_RANGE_SQ);
      end

      // Azimuth CORDIC step
      if (k >= AZ_FIRST && k < AZ_FIRST + lprip_pkg::CORDIC_STEPS) begin
        p.az = cord_iter(p.az, AI);
      end

      // Horizontal-range root step
      if (k >= SQ_FIRST && k < SQ_FIRST + HSQ_STEPS) begin
        hbit = 64'(1) << (62 - 2 * HI);
        if (p.h_rem >= p.h_res + hbit) begin
          p.h_rem = p.h_rem - (p.h_res + hbit);
          p.h_res = (p.h_res >> 1) + hbit;
        end else begin
          p.h_res = p.h_res >> 1;
        end
      end

      // Full-range root step
      if (k >= SQ_FIRST && k < SQ_FIRST + SSQ_STEPS) begin
        sbit = 48'(1) << (46 - 2 * SI);
        if (p.s_rem >= p.s_res + sbit) begin
          p.s_rem = p.s_rem - (p.s_res + sbit);
          p.s_res = (p.s_res >> 1) + sbit;
        end else begin
          p.s_res = p.s_res >> 1;
        end
      end

      // Elevation CORDIC step, loading the vector on the first one
      if (k >= EL_FIRST && k < EL_FIRST + lprip_pkg::CORDIC_STEPS) begin
        ce = p.el;
        if (k == EL_FIRST) begin
          ce.s   = {{4{p.pz[23]}}, p.pz, 20'b0};
          ce.c   = {4'b0, p.h_res[31:0], 12'b0};
          ce.ang = '0;
        end
        p.el = cord_iter(ce, EI);
      end

      // Offsets and magnitudes for both divisions
      if (k == PRE_DIV) begin
        n  = {p.el.ang[27], p.el.ang} + {3'b0, bottom_offset};
        nm = n[28] ? -n : n;
        p.r_neg = n[28];
        p.r_num = nm[26:0];
        p.r_rem = '0;
        p.r_q   = '0;
        a  = {p.az.ang[27], p.az.ang}
           - {lprip_pkg::ANG_HALF_PI[27], lprip_pkg::ANG_HALF_PI};
        am = a[28] ? -a : a;
        p.c_neg = a[28];
        p.c_num = 28'({am[27:0], 1'b0} + {3'b0, column_step});
        p.c_den = {column_step, 1'b0};
        p.c_rem = '0;
        p.c_q   = '0;
      end

      // Row quotient bit
      if (k >= DIV_FIRST && k < DIV_FIRST + ROW_QW) begin
        rr = {p.r_rem[26:0], p.r_num[RB]};
        if (rr >= {2'b0, row_step}) begin
          rr = rr - {2'b0, row_step};
          p.r_q[RB] = 1'b1;
        end
        p.r_rem = rr;
      end

      // Column quotient bit
      if (k >= DIV_FIRST && k < DIV_FIRST + COL_QW) begin
        cr = {p.c_rem[27:0], p.c_num[CB]};
        if (cr >= {2'b0, p.c_den}) begin
          cr = cr - {2'b0, p.c_den};
          p.c_q[CB] = 1'b1;
        end
        p.c_rem = cr;
      end

      // Column from the rounded quotient, halved toward zero
      if (k == COL_STG) begin
        q2 = {3'b0, p.c_q, 1'b0};
        v  = {20'b0, column_count} - (p.c_neg ? -q2 : q2);
        nv = -v;
        p.col = v[31] ? -(nv >> 1) : (v >> 1);
      end

      // Wrap once, check bounds, clear dropped points
      if (k == LAST) begin
        col2 = p.col;
        if (!p.col[31] && p.col >= {20'b0, column_count}) begin
          col2 = p.col - {20'b0, column_count};
        end
        col_ok = !col2[31] && (col2 < {20'b0, column_count})
                 && (col2 < 32'(lprip_pkg::MAX_COLUMNS));
        row_ok = !(p.r_neg && (p.r_q != '0)) && (p.r_q < {20'b0, row_count})
                 && (p.r_q < 27'(lprip_pkg::MAX_ROWS));
        p.keep_o = !p.short_range && (row_step != '0) && (column_step != '0)
                   && row_ok && col_ok;
        p.row_o  = p.keep_o ? p.r_q[5:0] : 6'b0;
        p.col_o  = p.keep_o ? col2[10:0] : 11'b0;
      end

      nxt[k] = p;
    end

    // Hold or advance this stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        if (k == 0) begin
          vld[k] <= in_valid;
        end else begin
          vld[k] <= vld[PK];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt[k];
      end
    end
  end

  // A kept point lies inside the configured image
  a_row_in_image: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keep) |-> ({1'b0, row} < row_count))
    else $error("kept point row outside image");

  a_col_in_image: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keep) |-> ({1'b0, column} < column_count))
    else $error("kept point column outside image");

  // A dropped point carries a zero position
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !keep) |-> (row == 6'b0 && column == 11'b0))
    else $error("dropped point with nonzero position");

  // A kept point is at least 0.1 m away
  a_min_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keep) |-> (distance >= 24'd409))
    else $error("kept point closer than minimum range");

  // A stall freezes the valid chain
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> (vld[LAST] == $past(vld[LAST]) && vld[0] == $past(vld[0])))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: sim/tb_lidar_point_range_image_projector_core.sv
`default_nettype none

module tb_lidar_point_range_image_projector_core;

  typedef struct packed {
    logic        keep;
    logic [5:0]  row;
    logic [10:0] column;
    logic [23:0] distance;
  } projection_t;

  localparam int  IDLE_LIMIT  = 20000;
  localparam int  DRAIN_WAIT  = 120;
  localparam longint HALF_PI_A = 26353589;
  localparam longint PI_A      = 52707179;
  localparam longint NEAR_SQ   = 167772;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic               out_valid;
  logic               out_ready;
  logic               keep;
  logic [5:0]         row;
  logic [10:0]        column;
  logic [23:0]        distance;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the image geometry registers
  longint      geo_rows;
  longint      geo_cols;
  longint      geo_offset;
  longint      geo_row_step;
  longint      geo_col_step;

  projection_t pending_proj[$];
  int          mismatch_count;
  int          burst_left;
  int          hold_left;
  int          ready_pct;
  int          idle_cycles;

  longint arctan_tab[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  lidar_point_range_image_projector_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .keep(keep), .row(row), .column(column), .distance(distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring rotation: angle of (c, s) in 2^-24 rad
  function automatic longint vector_angle(longint s, longint c);
    longint ang;
    longint dc;
    longint ds;
    ang = 0;
    s = s * 4096;
    c = c * 4096;
    if (c < 0) begin
      ang = (s >= 0) ? PI_A : -PI_A;
      c = -c;
      s = -s;
    end
    for (int i = 0; i < 24; i++) begin
      dc = s >>> i;
      ds = c >>> i;
      if (s >= 0) begin
        c = c + dc; s = s - ds; ang = ang + arctan_tab[i];
      end else begin
        c = c - dc; s = s + ds; ang = ang - arctan_tab[i];
      end
    end
    return ang;
  endfunction

  function automatic projection_t project_point(logic signed [23:0] px,
      logic signed [23:0] py, logic signed [23:0] pz);
    projection_t p;
    longint x, y, z, hsq, ssq, h, elev, r, c, az, a, mag, qm, q;
    longint unsigned range_root;
    logic ok;
    x = px; y = py; z = pz;
    hsq  = x * x + y * y;
    ssq  = hsq + z * z;
    range_root = int_root(ssq);
    r = 0; c = 0;
    ok = !(ssq <= NEAR_SQ || geo_row_step == 0 || geo_col_step == 0);
    if (ok) begin
      h    = int_root(longint'(hsq) << 16);
      elev = vector_angle(z * 256, h);
      r    = (elev + geo_offset) / geo_row_step;
      if (r < 0 || r >= geo_rows || r >= lprip_pkg::MAX_ROWS) ok = 1'b0;
    end
    if (ok) begin
      az  = vector_angle(x * 256, y * 256);
      a   = az - HALF_PI_A;
      mag = (a < 0) ? -a : a;
      qm  = (2 * mag + geo_col_step) / (2 * geo_col_step);
      q   = (a < 0) ? -qm : qm;
      c   = (geo_cols - 2 * q) / 2;
      if (c >= geo_cols) c = c - geo_cols;
      if (c < 0 || c >= geo_cols || c >= lprip_pkg::MAX_COLUMNS) ok = 1'b0;
    end
    if (!ok) begin
      r = 0; c = 0;
    end
    p.keep     = ok;
    p.row      = r[5:0];
    p.column   = c[10:0];
    p.distance = range_root[23:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Check each result transaction against the oldest projection
  always @(posedge clk) begin
    projection_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_proj.size() == 0) begin
        report_mismatch("unexpected result, keep", keep, 0);
      end else begin
        want = pending_proj.pop_front();
        if (keep !== want.keep) report_mismatch("keep", keep, want.keep);
        if (row !== want.row) report_mismatch("row", row, want.row);
        if (column !== want.column) report_mismatch("column", column, want.column);
        if (distance !== want.distance)
          report_mismatch("distance", distance, want.distance);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with long hold-offs on request
  initial begin
    int span;
    span = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 80;
          2: ready_pct = 50;
          default: ready_pct = 15;
        endcase
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  task automatic send_point(int x, int y, int z);
    int gap;
    // Close a burst with a random gap
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pos_x    <= 24'(x);
    pos_y    <= 24'(y);
    pos_z    <= 24'(z);
    do @(posedge clk); while (!in_ready);
    pending_proj.insert(pending_proj.size(), project_point(24'(x), 24'(y), 24'(z)));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    stop_sending();
    while (pending_proj.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(lprip_pkg::reg_idx_t idx, longint value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= value[31:0];
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      lprip_pkg::REG_ROW_COUNT:     geo_rows     = value & 64'h7F;
      lprip_pkg::REG_COLUMN_COUNT:  geo_cols     = value & 64'hFFF;
      lprip_pkg::REG_BOTTOM_OFFSET: geo_offset   = value & 64'h3FFFFFF;
      lprip_pkg::REG_ROW_STEP:      geo_row_step = value & 64'h3FFFFFF;
      default:                      geo_col_step = value & 64'h3FFFFFF;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(longint rows, longint cols, longint offs,
      longint rstep, longint cstep);
    write_reg(lprip_pkg::REG_ROW_COUNT, rows);
    write_reg(lprip_pkg::REG_COLUMN_COUNT, cols);
    write_reg(lprip_pkg::REG_BOTTOM_OFFSET, offs);
    write_reg(lprip_pkg::REG_ROW_STEP, rstep);
    write_reg(lprip_pkg::REG_COLUMN_STEP, cstep);
  endtask

  // Mostly scene-like points, plus full-range and near-origin noise
  task automatic send_random_point();
    logic signed [23:0] x, y, z;
    int lim;
    case ($urandom_range(0, 9))
      0, 1: begin
        x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
      end
      2: begin
        x = 24'(int'($urandom_range(0, 1200)) - 600);
        y = 24'(int'($urandom_range(0, 1200)) - 600);
        z = 24'(int'($urandom_range(0, 400)) - 200);
      end
      default: begin
        lim = $urandom_range(2000, 2000000);
        x = 24'(int'($urandom_range(0, 2 * lim)) - lim);
        y = 24'(int'($urandom_range(0, 2 * lim)) - lim);
        lim = lim / $urandom_range(2, 16);
        z = 24'(int'($urandom_range(0, 2 * lim)) - lim);
      end
    endcase
    send_point(x, y, z);
  endtask

  task automatic test_directed_points();
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(-24'sh800000, -24'sh800000, -24'sh800000);
    send_point(24'sh7FFFFF, -24'sh800000, 0);
    send_point(0, 0, 0);
    // Either side of the minimum range
    send_point(409, 22, 0);
    send_point(409, 23, 0);
    send_point(0, 0, 410);
    // Azimuth along each axis and across the branch cut
    send_point(0, 4096, 0);
    send_point(4096, 0, 0);
    send_point(-4096, 0, 0);
    send_point(0, -4096, 0);
    send_point(1, -4096, 0);
    send_point(-1, -4096, 0);
    // Elevation extremes
    send_point(0, 4096, 40960);
    send_point(0, 4096, -40960);
    send_point(40960, 40960, 500);
    send_point(40960, 40960, -5000);
    send_point(-300000, 200000, 12000);
    send_point(123456, -654321, -30000);
    send_point(24'sh555555, -24'sh2AAAAA, 24'sh0F0F0F);
    drain_results();
  endtask

  task automatic test_geometry_sweep();
    set_geometry(64, 2048, 0, 1, 1);
    repeat (40) send_random_point();
    drain_results();
    set_geometry(1, 2, 52707179, 52707179, 52707179);
    repeat (40) send_random_point();
    drain_results();
    set_geometry(64, 1801, 26353589, 823550, 29443);
    repeat (60) send_random_point();
    drain_results();
    set_geometry(32, 3, 4421581, 52707179, 1);
    repeat (40) send_random_point();
    drain_results();
    set_geometry(7, 901, 52707179, 1, 117127);
    repeat (40) send_random_point();
    drain_results();
    // Random geometries within range
    repeat (6) begin
      set_geometry($urandom_range(1, 64), $urandom_range(2, 2048),
                   $urandom_range(0, 52707179), $urandom_range(1, 2000000),
                   $urandom_range(1, 200000));
      repeat (60) send_random_point();
      drain_results();
    end
  endtask

  task automatic test_scene_stream();
    set_geometry(lprip_pkg::RST_ROW_COUNT, lprip_pkg::RST_COLUMN_COUNT,
                 lprip_pkg::RST_BOTTOM_OFFSET, lprip_pkg::RST_ROW_STEP,
                 lprip_pkg::RST_COLUMN_STEP);
    repeat (420) send_random_point();
    drain_results();
  endtask

  task automatic test_backpressure();
    set_geometry(64, 2048, 26353589, 823550, 25736);
    hold_left = 400;
    burst_left = 1000;
    repeat (250) send_random_point();
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    mismatch_count = 0;
    burst_left = 0;
    hold_left = 0;
    ready_pct = 100;
    idle_cycles = 0;
    geo_rows     = lprip_pkg::RST_ROW_COUNT;
    geo_cols     = lprip_pkg::RST_COLUMN_COUNT;
    geo_offset   = lprip_pkg::RST_BOTTOM_OFFSET;
    geo_row_step = lprip_pkg::RST_ROW_STEP;
    geo_col_step = lprip_pkg::RST_COLUMN_STEP;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_points();
    test_geometry_sweep();
    test_scene_stream();
    test_backpressure();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
